[design/stc_pkg.sv]
// shared types, codes and helpers of the space-to-tab compressor
// no dependencies
package stc_pkg;

  localparam int MAX_TAB_WIDTH = 16;
  localparam int TW_BITS       = 5;   // width of the stop width register
  localparam int COL_BITS      = $clog2(MAX_TAB_WIDTH);  // column and held-space counters
  localparam int LEN_BITS      = 32;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;

  localparam logic [TW_BITS-1:0] STOP_WIDTH_RESET = TW_BITS'(8);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } stc_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // take the input item
    logic emit;   // move the next result into the output register
  } stc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic work_left;  // results of the current item still to send
    logic final_one;  // the next result is the last of the item
    logic out_free;   // output register can take a result this cycle
  } stc_status_t;

  // clamp the register value to 1..MAX_TAB_WIDTH
  function automatic logic [TW_BITS-1:0] eff_width(input logic [TW_BITS-1:0] tw);
    logic [TW_BITS-1:0] w;
    if (tw == '0) begin
      w = TW_BITS'(1);
    end else if (tw > TW_BITS'(MAX_TAB_WIDTH)) begin
      w = TW_BITS'(MAX_TAB_WIDTH);
    end else begin
      w = tw;
    end
    return w;
  endfunction

endpackage

[design/stc_ctrl.sv]
// controller state machine of the space-to-tab compressor
// depends on stc_pkg
module stc_ctrl import stc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  stc_status_t status,
  output stc_cmd_t    cmd
);

  stc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!status.work_left) begin
          state_nxt = ST_IDLE;
        end else if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.final_one) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[design/stc_datapath.sv]
// datapath of the space-to-tab compressor: column state, held spaces,
// result sequencing, length counter and output register; depends on stc_pkg
module stc_datapath import stc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [TW_BITS-1:0]  cfg_wdata,
  input  logic [7:0]          in_byte,
  input  logic                in_end_of_text,
  input  stc_cmd_t            cmd,
  output stc_status_t         status,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_run_end,
  output logic                out_text_end,
  output logic [LEN_BITS-1:0] out_text_length
);

  logic [TW_BITS-1:0]  stop_width_r;
  logic [COL_BITS-1:0] col_r, col_nxt;
  logic [COL_BITS-1:0] pend_r, pend_nxt;
  logic [COL_BITS-1:0] flush_r, flush_nxt;
  logic                has_main_r, has_main_nxt;
  logic [7:0]          main_r, main_nxt;
  logic                last_r;
  logic [LEN_BITS-1:0] cnt_r;
  logic                out_valid_r;
  logic [7:0]          out_byte_r;
  logic                out_run_end_r;
  logic                out_text_end_r;
  logic [LEN_BITS-1:0] out_len_r;

  logic [TW_BITS-1:0]  w;
  logic [TW_BITS-1:0]  col_inc;
  logic [TW_BITS-1:0]  pend_inc;
  logic                stop_hit;
  logic [LEN_BITS-1:0] cnt_inc;
  logic                final_one;

  // plan of the item: held spaces to release, then an optional main byte
  always_comb begin
    w            = eff_width(stop_width_r);
    col_inc      = {1'b0, col_r} + TW_BITS'(1);
    pend_inc     = {1'b0, pend_r} + TW_BITS'(1);
    stop_hit     = col_inc >= w;
    col_nxt      = stop_hit ? '0 : col_inc[COL_BITS-1:0];
    pend_nxt     = '0;
    flush_nxt    = pend_r;
    has_main_nxt = 1'b1;
    main_nxt     = in_byte;
    if (in_byte == CH_SPACE) begin
      flush_nxt = '0;
      if (stop_hit) begin
        main_nxt = (pend_inc >= TW_BITS'(2)) ? CH_TAB : CH_SPACE;
      end else begin
        has_main_nxt = 1'b0;
        pend_nxt     = pend_inc[COL_BITS-1:0];
        if (in_end_of_text) begin
          flush_nxt = pend_inc[COL_BITS-1:0];
        end
      end
    end else if (in_byte == CH_TAB) begin
      flush_nxt = '0;
      col_nxt   = '0;
    end else if (in_byte == CH_NL) begin
      col_nxt = '0;
    end
    if (in_end_of_text) begin
      col_nxt  = '0;
      pend_nxt = '0;
    end
  end

  assign cnt_inc   = (cnt_r == '1) ? cnt_r : cnt_r + LEN_BITS'(1);
  assign final_one = (flush_r == '0) || ((flush_r == COL_BITS'(1)) && !has_main_r);

  assign status.work_left = (flush_r != '0) || has_main_r;
  assign status.final_one = final_one;
  assign status.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_width_r <= STOP_WIDTH_RESET;
      col_r        <= '0;
      pend_r       <= '0;
      flush_r      <= '0;
      has_main_r   <= 1'b0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        stop_width_r <= cfg_wdata;
      end
      if (cmd.load) begin
        col_r      <= col_nxt;
        pend_r     <= pend_nxt;
        flush_r    <= flush_nxt;
        has_main_r <= has_main_nxt;
      end else if (cmd.emit) begin
        if (flush_r != '0) begin
          flush_r <= flush_r - COL_BITS'(1);
        end else begin
          has_main_r <= 1'b0;
        end
      end
      if (cmd.emit) begin
        cnt_r <= (final_one && last_r) ? '0 : cnt_inc;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      main_r <= main_nxt;
      last_r <= in_end_of_text;
    end
    if (cmd.emit) begin
      out_byte_r     <= (flush_r != '0) ? CH_SPACE : main_r;
      out_run_end_r  <= final_one;
      out_text_end_r <= final_one && last_r;
      out_len_r      <= (final_one && last_r) ? cnt_inc : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_run_end     = out_run_end_r;
  assign out_text_end    = out_text_end_r;
  assign out_text_length = out_len_r;

endmodule

[design/space_to_tab_compressor.sv]
// top level of the space-to-tab compressor: controller plus datapath
// depends on stc_pkg, stc_ctrl, stc_datapath
//
//   channel  handshake              payload
//   in       in_valid / in_ready    in_byte[7:0], in_end_of_text
//   out      out_valid / out_ready  out_byte[7:0], out_run_end, out_text_end,
//                                   out_text_length[31:0]
//   cfg      cfg_we                 cfg_wdata[4:0] (tab width)
//
// an item is accepted in the idle state, then its n results (0..16) go out one
// per cycle, unless the output stalls, through the single output register; an
// item with no results still passes through the emit state
// a stalled output holds the emit sequence; the next item is accepted while
// the final result waits in the output register
// reset is synchronous, active low: tab width 8, column, held spaces and
// length counter cleared
module space_to_tab_compressor import stc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [TW_BITS-1:0]  cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                in_end_of_text,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_run_end,
  output logic                out_text_end,
  output logic [LEN_BITS-1:0] out_text_length
);

  stc_cmd_t    cmd;
  stc_status_t status;

  // sequencing: idle takes an item, emit walks its results
  stc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // tab-stop tracking, held spaces, length count and output register
  stc_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_byte         (in_byte),
    .in_end_of_text  (in_end_of_text),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_run_end     (out_run_end),
    .out_text_end    (out_text_end),
    .out_text_length (out_text_length)
  );

endmodule

[design/stc_checker.sv]
// port-level checks of the space-to-tab compressor, bound to the top level
// depends on stc_pkg and space_to_tab_compressor
module stc_checker import stc_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [7:0]          out_byte,
  input logic                out_run_end,
  input logic                out_text_end,
  input logic [LEN_BITS-1:0] out_text_length
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("stalled result changed");

  // the end of a text always closes an item's run
  a_text_end_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_text_end |-> out_run_end)
    else $error("text end without run end");

  // the length is shown only on the end of a text
  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_text_end |-> out_text_length == '0)
    else $error("length outside text end");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind space_to_tab_compressor stc_checker u_stc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_byte        (out_byte),
  .out_run_end     (out_run_end),
  .out_text_end    (out_text_end),
  .out_text_length (out_text_length)
);
